>>> rtl/ucp_pkg.sv
`timescale 1ns / 1ps
package ucp_pkg;

	localparam int IN_WIDTH  = 16;
	localparam int OUT_FRAC  = 14;
	localparam int OUT_WIDTH = OUT_FRAC + 2;
	localparam int MAG_WIDTH = 2 * IN_WIDTH;       // |cross component| <= 2^(2*IN_WIDTH-1)
	localparam int LEN_WIDTH = 2 * MAG_WIDTH;      // squared length
	localparam int ROOT_WIDTH = MAG_WIDTH;         // floor sqrt of squared length
	localparam int SQRT_STEPS = LEN_WIDTH / 2;
	localparam int Q_WIDTH   = OUT_FRAC + 1;       // quotient magnitude <= 2^OUT_FRAC
	localparam int NUM_WIDTH = MAG_WIDTH + OUT_FRAC;

	typedef struct packed {
		logic signed [IN_WIDTH-1:0] a_x;
		logic signed [IN_WIDTH-1:0] a_y;
		logic signed [IN_WIDTH-1:0] a_z;
		logic signed [IN_WIDTH-1:0] b_x;
		logic signed [IN_WIDTH-1:0] b_y;
		logic signed [IN_WIDTH-1:0] b_z;
	} ucp_in_t;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] n_x;
		logic signed [OUT_WIDTH-1:0] n_y;
		logic signed [OUT_WIDTH-1:0] n_z;
		logic                        zero_length;
	} ucp_out_t;

	// cross product as magnitude and sign per component
	typedef struct packed {
		logic [2:0][MAG_WIDTH-1:0] mag;
		logic [2:0]                neg;
	} ucp_vec_t;

endpackage

>>> rtl/ucp_front.sv
`timescale 1ns / 1ps
module ucp_front import ucp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  ucp_in_t              in_data,
	output logic                 out_vld,
	output ucp_vec_t             out_vec,
	output logic [LEN_WIDTH-1:0] out_len2
);

	logic [5:0][MAG_WIDTH-1:0] prod_s1;
	logic                      vld_s1, vld_s2, vld_s3, vld_s4;
	ucp_vec_t                  vec_s2, vec_s3, vec_s4;
	logic [2:0][LEN_WIDTH-1:0] sq_s3;
	logic [LEN_WIDTH-1:0]      len2_s4;
	logic signed [MAG_WIDTH:0] diff [3];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// stage 1: six signed partial products
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1[0] <= in_data.a_y * in_data.b_z;
			prod_s1[1] <= in_data.a_z * in_data.b_y;
			prod_s1[2] <= in_data.a_z * in_data.b_x;
			prod_s1[3] <= in_data.a_x * in_data.b_z;
			prod_s1[4] <= in_data.a_x * in_data.b_y;
			prod_s1[5] <= in_data.a_y * in_data.b_x;
		end
	end

	// stage 2: differences, split into magnitude and sign
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = (MAG_WIDTH+1)'(signed'(prod_s1[2*i]))
				- (MAG_WIDTH+1)'(signed'(prod_s1[2*i+1]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				vec_s2.neg[i] <= diff[i][MAG_WIDTH];
				vec_s2.mag[i] <= diff[i][MAG_WIDTH] ? MAG_WIDTH'(-diff[i])
					: diff[i][MAG_WIDTH-1:0];
			end
		end
	end

	// stage 3: squares
	always_ff @(posedge clk) begin
		if (en) begin
			vec_s3 <= vec_s2;
			for (int i = 0; i < 3; i++) begin
				sq_s3[i] <= vec_s2.mag[i] * vec_s2.mag[i];
			end
		end
	end

	// stage 4: squared length
	always_ff @(posedge clk) begin
		if (en) begin
			vec_s4  <= vec_s3;
			len2_s4 <= sq_s3[0] + sq_s3[1] + sq_s3[2];
		end
	end

	assign out_vld  = vld_s4;
	assign out_vec  = vec_s4;
	assign out_len2 = len2_s4;

endmodule

>>> rtl/ucp_sqrt.sv
`timescale 1ns / 1ps
module ucp_sqrt import ucp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  ucp_vec_t              in_vec,
	input  logic [LEN_WIDTH-1:0]  in_len2,
	output logic                  out_vld,
	output ucp_vec_t              out_vec,
	output logic [ROOT_WIDTH-1:0] out_root
);

	// one result bit per stage, digit-by-digit square root
	logic                 vld_s [SQRT_STEPS+1];
	ucp_vec_t             vec_s [SQRT_STEPS+1];
	logic [LEN_WIDTH-1:0] op_s  [SQRT_STEPS+1];
	logic [LEN_WIDTH-1:0] res_s [SQRT_STEPS+1];

	assign vld_s[0] = in_vld;
	assign vec_s[0] = in_vec;
	assign op_s[0]  = in_len2;
	assign res_s[0] = '0;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [LEN_WIDTH-1:0] ONE = LEN_WIDTH'(1) << (LEN_WIDTH - 2 - 2*k);
		logic [LEN_WIDTH:0] trial;
		logic               fits;

		assign trial = {1'b0, res_s[k]} + {1'b0, ONE};
		assign fits  = {1'b0, op_s[k]} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				vec_s[k+1] <= vec_s[k];
				if (fits) begin
					op_s[k+1]  <= op_s[k] - trial[LEN_WIDTH-1:0];
					res_s[k+1] <= (res_s[k] >> 1) + ONE;
				end else begin
					op_s[k+1]  <= op_s[k];
					res_s[k+1] <= res_s[k] >> 1;
				end
			end
		end
	end

	assign out_vld  = vld_s[SQRT_STEPS];
	assign out_vec  = vec_s[SQRT_STEPS];
	assign out_root = res_s[SQRT_STEPS][ROOT_WIDTH-1:0];

endmodule

>>> rtl/ucp_div.sv
`timescale 1ns / 1ps
module ucp_div import ucp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_vld,
	input  ucp_vec_t                in_vec,
	input  logic [ROOT_WIDTH-1:0]   in_root,
	output logic                    out_vld,
	output ucp_vec_t                out_vec,
	output logic [2:0][Q_WIDTH-1:0] out_q
);

	// restoring division, one quotient bit per stage, three lanes in step
	logic                          vld_s  [Q_WIDTH+1];
	ucp_vec_t                      vec_s  [Q_WIDTH+1];
	logic [ROOT_WIDTH-1:0]         den_s  [Q_WIDTH+1];
	logic [2:0][NUM_WIDTH-1:0]     rem_s  [Q_WIDTH+1];
	logic [2:0][Q_WIDTH-1:0]       q_s    [Q_WIDTH+1];

	assign vld_s[0] = in_vld;
	assign vec_s[0] = in_vec;
	assign den_s[0] = in_root;
	assign q_s[0]   = '0;
	for (genvar l = 0; l < 3; l++) begin : g_num
		assign rem_s[0][l] = {in_vec.mag[l], {OUT_FRAC{1'b0}}};
	end

	for (genvar k = 0; k < Q_WIDTH; k++) begin : g_step
		localparam int BIT = Q_WIDTH - 1 - k;
		localparam logic [Q_WIDTH-1:0] QBIT = Q_WIDTH'(1) << BIT;
		logic [NUM_WIDTH:0] dsh;

		assign dsh = (NUM_WIDTH+1)'(den_s[k]) << BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				vec_s[k+1] <= vec_s[k];
				den_s[k+1] <= den_s[k];
				for (int l = 0; l < 3; l++) begin
					if ({1'b0, rem_s[k][l]} >= dsh) begin
						rem_s[k+1][l] <= rem_s[k][l] - dsh[NUM_WIDTH-1:0];
						q_s[k+1][l]   <= q_s[k][l] | QBIT;
					end else begin
						rem_s[k+1][l] <= rem_s[k][l];
						q_s[k+1][l]   <= q_s[k][l];
					end
				end
			end
		end
	end

	assign out_vld = vld_s[Q_WIDTH];
	assign out_vec = vec_s[Q_WIDTH];
	assign out_q   = q_s[Q_WIDTH];

endmodule

>>> rtl/unit_cross_product_top.sv
`timescale 1ns / 1ps
// Unit normal of two 3-D vectors: forms the exact cross product, divides each
// component by floor(sqrt(|C|^2)) and returns it truncated toward zero in
// Q1.14, with zero_length set and a zero vector when the product vanishes.
// Fully pipelined: one transaction per cycle in and out. The stages are the
// products, differences, squares and squared length in the front, then the
// one-bit-per-stage square root, the one-bit-per-stage dividers, and last
// sign restore and output register. The whole pipe holds while a
// finished result waits and out_ready is low.
module unit_cross_product_top import ucp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  ucp_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output ucp_out_t out_data
);

	logic                    en;
	logic                    fr_vld, sq_vld, dv_vld;
	ucp_vec_t                fr_vec, sq_vec, dv_vec;
	logic [LEN_WIDTH-1:0]    fr_len2;
	logic [ROOT_WIDTH-1:0]   sq_root;
	logic [2:0][Q_WIDTH-1:0] dv_q;
	logic                    out_vld_q;
	ucp_out_t                out_q;
	ucp_out_t                res;

	// pipe advances whenever the output slot is free or being drained
	assign en       = !out_vld_q || out_ready;
	assign in_ready = en;

	ucp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (in_valid),
		.in_data  (in_data),
		.out_vld  (fr_vld),
		.out_vec  (fr_vec),
		.out_len2 (fr_len2)
	);

	ucp_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (fr_vld),
		.in_vec   (fr_vec),
		.in_len2  (fr_len2),
		.out_vld  (sq_vld),
		.out_vec  (sq_vec),
		.out_root (sq_root)
	);

	ucp_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (sq_vld),
		.in_vec  (sq_vec),
		.in_root (sq_root),
		.out_vld (dv_vld),
		.out_vec (dv_vec),
		.out_q   (dv_q)
	);

	// sign restore and zero-length override
	always_comb begin
		res.zero_length = (dv_vec.mag == '0);
		if (res.zero_length) begin
			res.n_x = '0;
			res.n_y = '0;
			res.n_z = '0;
		end else begin
			res.n_x = dv_vec.neg[0] ? -OUT_WIDTH'(dv_q[0]) : OUT_WIDTH'(dv_q[0]);
			res.n_y = dv_vec.neg[1] ? -OUT_WIDTH'(dv_q[1]) : OUT_WIDTH'(dv_q[1]);
			res.n_z = dv_vec.neg[2] ? -OUT_WIDTH'(dv_q[2]) : OUT_WIDTH'(dv_q[2]);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= res;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	localparam logic signed [OUT_WIDTH-1:0] NMAX = OUT_WIDTH'(1) << OUT_FRAC;

	a_zero_vec : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.zero_length |->
			out_data.n_x == '0 && out_data.n_y == '0 && out_data.n_z == '0)
		else $error("zero_length with nonzero normal");

	a_range : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.n_x <= NMAX && out_data.n_x >= -NMAX
			&& out_data.n_y <= NMAX && out_data.n_y >= -NMAX
			&& out_data.n_z <= NMAX && out_data.n_z >= -NMAX)
		else $error("normal component out of range");

	a_stall_hold : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(u_div.out_q))
		else $error("pipeline moved during stall");

endmodule
